### sv/queue_machine_instruction_step_assert.svh
// assertion macros for the queue machine instruction step
`ifndef QUEUE_MACHINE_INSTRUCTION_STEP_ASSERT_SVH
`define QUEUE_MACHINE_INSTRUCTION_STEP_ASSERT_SVH

// implication checked every clock, quiet during reset
`define QMIS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define QMIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/qmis_pkg.sv
// package: widths, opcodes and shared types of the queue machine
package qmis_pkg;

    localparam int QUEUE_DEPTH_DEF   = 256;
    localparam int PROGRAM_DEPTH_DEF = 1024;
    localparam int NUM_REGS_DEF      = 26;

    localparam int ACTION_W = 5;
    localparam int DATA_W   = 16;
    localparam int REGIDX_W = 5;
    localparam int TARGET_W = 10;
    localparam int LINE_W   = 11;

    typedef enum logic [ACTION_W-1:0] {
        OP_PUSH     = 5'd0,
        OP_ADD      = 5'd1,
        OP_SUB      = 5'd2,
        OP_MUL      = 5'd3,
        OP_DIV      = 5'd4,
        OP_MOD      = 5'd5,
        OP_SETREG   = 5'd6,
        OP_GETREG   = 5'd7,
        OP_PRINTQ   = 5'd8,
        OP_PRINTREG = 5'd9,
        OP_CHARQ    = 5'd10,
        OP_CHARREG  = 5'd11,
        OP_LABEL    = 5'd12,
        OP_JUMP     = 5'd13,
        OP_JZ       = 5'd14,
        OP_JEQ      = 5'd15,
        OP_JGT      = 5'd16,
        OP_QUIT     = 5'd17
    } opcode_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   immediate;
        logic [REGIDX_W-1:0] reg_a;
        logic [REGIDX_W-1:0] reg_b;
        logic [TARGET_W-1:0] target_line;
    } instr_t;

    typedef struct packed {
        logic [LINE_W-1:0] next_line;
        logic              halted;
        logic              print_valid;
        logic              print_is_char;
        logic [DATA_W-1:0] print_value;
        logic              queue_overflow;
    } result_t;

    // divider handshake
    typedef struct packed {
        logic start;
        logic is_mod;
    } div_ctl_t;

endpackage

### sv/qmis_if.sv
// valid/ready channel interfaces for instruction, result and configuration
interface qmis_instr_if;
    import qmis_pkg::*;
    logic   valid;
    logic   ready;
    instr_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qmis_result_if;
    import qmis_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qmis_cfg_if;
    import qmis_pkg::*;
    logic              valid;
    logic              ready;
    logic [LINE_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/queue_machine_instruction_step.sv
// top level: queue machine instruction step with memory-held queue and registers
//
//  channel   dir  payload
//  instr     in   action, immediate, reg_a, reg_b, target_line
//  result    out  next_line, halted, print flags/value, queue_overflow
//  cfg       in   program_length
//
// the instr transfer is followed by the read state, and the result is registered in the
// write state. arithmetic with two entries queued also passes the pop and calc states; div and
// mod then wait in the divider state for 16 divider steps and done. queue and register file
// are synchronous memories with registered read data. reset returns the machine to line 0.
// a result waiting in the output register stalls the next instruction.
module queue_machine_instruction_step #(
    parameter int QUEUE_DEPTH   = qmis_pkg::QUEUE_DEPTH_DEF,
    parameter int PROGRAM_DEPTH = qmis_pkg::PROGRAM_DEPTH_DEF,
    parameter int NUM_REGS      = qmis_pkg::NUM_REGS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    qmis_instr_if.sink   instr,
    qmis_result_if.source result,
    qmis_cfg_if.sink     cfg
);
    import qmis_pkg::*;

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RA_W = $clog2(NUM_REGS);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_POPY  = 7'b0000100,
        ST_CALC  = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    instr_t            ins_reg;
    logic [LINE_W-1:0] plen_reg;
    logic [LINE_W-1:0] pc_reg;
    logic              halt_reg;
    logic [QA_W-1:0]   head_reg, tail_reg;
    logic [QC_W-1:0]   count_reg;
    logic [NUM_REGS-1:0] rvalid_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic [DATA_W-1:0] qmem [QUEUE_DEPTH];
    logic [DATA_W-1:0] rmem [NUM_REGS];
    logic [DATA_W-1:0] q_rd_reg;
    logic [DATA_W-1:0] ra_rd_reg, rb_rd_reg;
    logic              ra_ok_reg, rb_ok_reg;
    logic [DATA_W-1:0] x_reg, y_reg, r_reg;
    logic [31:0]       prod;

    logic              q_we, r_we;
    logic [QA_W-1:0]   q_wa;
    logic [DATA_W-1:0] q_wd, r_wd;
    logic [RA_W-1:0]   r_wa;
    logic [QA_W-1:0]   q_ra;

    div_ctl_t          dctl;
    logic              ddone;
    logic [DATA_W-1:0] dres;

    logic [DATA_W-1:0] va, vb;
    logic              ra_in, rb_in;
    opcode_t           op;

    function automatic logic [QA_W-1:0] wrap_inc(input logic [QA_W-1:0] i);
        return ({1'b0, i} + (QA_W+1)'(1) >= (QA_W+1)'(QUEUE_DEPTH)) ? '0 : i + QA_W'(1);
    endfunction

    assign op    = opcode_t'(ins_reg.action);
    assign ra_in = ins_reg.reg_a < REGIDX_W'(NUM_REGS);
    assign rb_in = ins_reg.reg_b < REGIDX_W'(NUM_REGS);
    assign va    = ra_ok_reg ? ra_rd_reg : '0;
    assign vb    = rb_ok_reg ? rb_rd_reg : '0;

    assign instr.ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // queue read address follows head, moved on for the second arithmetic operand
    assign q_ra = (state_reg == ST_READ && arith) ? wrap_inc(head_reg) : head_reg;

    always_ff @(posedge clk)
    begin
        if (q_we)
            qmem[q_wa] <= q_wd;
        q_rd_reg <= qmem[q_ra];
        if (r_we)
            rmem[r_wa] <= r_wd;
        ra_rd_reg <= rmem[ins_reg.reg_a[RA_W-1:0]];
        rb_rd_reg <= rmem[ins_reg.reg_b[RA_W-1:0]];
        ra_ok_reg <= ra_in && rvalid_reg[ins_reg.reg_a[RA_W-1:0]];
        rb_ok_reg <= rb_in && rvalid_reg[ins_reg.reg_b[RA_W-1:0]];
    end

    qmis_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dctl),
        .dividend (x_reg),
        .divisor  (y_reg),
        .done     (ddone),
        .result   (dres)
    );

    assign prod = x_reg * y_reg;

    logic               arith;
    logic [LINE_W-1:0]  nxt;
    logic               jmp;
    result_t            res;
    logic [LINE_W-1:0]  cfg_sat;

    assign arith   = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL)
                  || (op == OP_DIV) || (op == OP_MOD);
    assign cfg_sat = ({1'b0, cfg.data} > (LINE_W+1)'(PROGRAM_DEPTH))
                   ? LINE_W'(PROGRAM_DEPTH) : cfg.data;

    always_comb
    begin
        jmp = 1'b0;
        case (op)
            OP_JUMP: jmp = 1'b1;
            OP_JZ:   jmp = (va == '0);
            OP_JEQ:  jmp = (va == vb);
            OP_JGT:  jmp = (va > vb);
            default: jmp = 1'b0;
        endcase
        nxt = jmp ? (LINE_W'(ins_reg.target_line) + LINE_W'(1)) : (pc_reg + LINE_W'(1));
        res = '0;
        if (halt_reg)
        begin
            res.next_line = pc_reg;
            res.halted    = 1'b1;
        end
        else
        begin
            res.next_line = (op == OP_QUIT) ? pc_reg : nxt;
            res.halted    = (op == OP_QUIT) || (nxt >= plen_reg);
            case (op)
                OP_PUSH, OP_GETREG:
                    res.queue_overflow = (count_reg == QC_W'(QUEUE_DEPTH));
                OP_PRINTQ, OP_CHARQ:
                begin
                    res.print_valid   = (count_reg != '0);
                    res.print_is_char = (count_reg != '0) && (op == OP_CHARQ);
                    res.print_value   = (count_reg == '0) ? '0
                                      : (op == OP_CHARQ) ? {8'd0, q_rd_reg[7:0]} : q_rd_reg;
                end
                OP_PRINTREG, OP_CHARREG:
                begin
                    res.print_valid   = 1'b1;
                    res.print_is_char = (op == OP_CHARREG);
                    res.print_value   = (op == OP_CHARREG) ? {8'd0, va[7:0]} : va;
                end
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        dctl = '0;
        q_we = 1'b0;
        q_wa = tail_reg;
        q_wd = r_reg;
        r_we = 1'b0;
        r_wa = ins_reg.reg_a[RA_W-1:0];
        r_wd = q_rd_reg;
        unique case (state_reg)
            ST_IDLE:  if (instr.valid && instr.ready) state_next = ST_READ;
            ST_READ:  state_next = (!halt_reg && arith && count_reg >= QC_W'(2))
                                 ? ST_POPY : ST_WRITE;
            ST_POPY:  state_next = ST_CALC;
            ST_CALC:
            begin
                if (op == OP_DIV || op == OP_MOD)
                begin
                    dctl.start  = 1'b1;
                    dctl.is_mod = (op == OP_MOD);
                    state_next  = ST_DIV;
                end
                else
                    state_next = ST_WRITE;
            end
            ST_DIV:   if (ddone) state_next = ST_WRITE;
            ST_WRITE:
            begin
                state_next = ST_OUT;
                if (!halt_reg)
                begin
                    if (arith && count_reg >= QC_W'(2))
                    begin
                        q_we = 1'b1;
                        q_wd = (op == OP_DIV || op == OP_MOD) ? dres : r_reg;
                    end
                    else if ((op == OP_PUSH || op == OP_GETREG)
                             && count_reg != QC_W'(QUEUE_DEPTH))
                    begin
                        q_we = 1'b1;
                        q_wd = (op == OP_PUSH) ? ins_reg.immediate : va;
                    end
                    else if (op == OP_SETREG && count_reg != '0 && ra_in)
                        r_we = 1'b1;
                end
            end
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plen_reg      <= LINE_W'(1);
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                plen_reg <= cfg_sat;
            if (result.valid && result.ready)
                out_valid_reg <= 1'b0;
            if (r_we)
                rvalid_reg[r_wa] <= 1'b1;
            if (state_reg == ST_WRITE)
            begin
                out_valid_reg <= 1'b1;
                pc_reg   <= res.next_line;
                halt_reg <= res.halted;
                if (!halt_reg)
                begin
                    if (arith && count_reg >= QC_W'(2))
                    begin
                        head_reg  <= wrap_inc(wrap_inc(head_reg));
                        tail_reg  <= wrap_inc(tail_reg);
                        count_reg <= count_reg - QC_W'(1);
                    end
                    else if (q_we)
                    begin
                        tail_reg  <= wrap_inc(tail_reg);
                        count_reg <= count_reg + QC_W'(1);
                    end
                    else if ((op == OP_SETREG || op == OP_PRINTQ || op == OP_CHARQ)
                             && count_reg != '0)
                    begin
                        head_reg  <= wrap_inc(head_reg);
                        count_reg <= count_reg - QC_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr.valid && instr.ready)
            ins_reg <= instr.data;
        if (state_reg == ST_READ)
            x_reg <= q_rd_reg;
        if (state_reg == ST_POPY)
            y_reg <= q_rd_reg;
        if (state_reg == ST_CALC)
        begin
            case (op)
                OP_ADD:  r_reg <= x_reg + y_reg;
                OP_SUB:  r_reg <= x_reg - y_reg;
                default: r_reg <= prod[DATA_W-1:0];
            endcase
        end
        if (state_reg == ST_WRITE)
            out_reg <= res;
    end

`include "queue_machine_instruction_step_assert.svh"

    `QMIS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= QC_W'(QUEUE_DEPTH))
    `QMIS_ASSERT_IMP(a_no_accept_busy, state_reg != ST_IDLE, !instr.ready)
    `QMIS_ASSERT_NEXT(a_halt_sticks, halt_reg, halt_reg)
    `QMIS_ASSERT_IMP(a_div_only_div, state_reg == ST_DIV, op == OP_DIV || op == OP_MOD)
    `QMIS_ASSERT_NEXT(a_write_then_out, state_reg == ST_WRITE, out_valid_reg)

endmodule

### sv/qmis_divider.sv
// radix-2 restoring divider, one quotient bit per cycle, zero divisor gives 0
module qmis_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qmis_pkg::div_ctl_t       ctl,
    input  logic [qmis_pkg::DATA_W-1:0] dividend,
    input  logic [qmis_pkg::DATA_W-1:0] divisor,
    output logic                     done,
    output logic [qmis_pkg::DATA_W-1:0] result
);
    import qmis_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              busy_reg, busy_next;
    logic              mod_reg, mod_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        mod_next  = mod_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            mod_next  = ctl.is_mod;
            cnt_next  = CNT_W'(DATA_W);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (diff[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg <= mod_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done   = done_reg;
    assign result = (den_reg == '0) ? '0 : (mod_reg ? rem_reg : quo_reg);

endmodule
